// File: rtl/stripe_request_splitter_unit_macros.svh
// Assertion macros for the stripe splitter RTL.
`ifndef STRIPE_REQUEST_SPLITTER_UNIT_MACROS_SVH
`define STRIPE_REQUEST_SPLITTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked while out of reset
`define SRSPLIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define SRSPLIT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRSPLIT_ASSERT(lbl, prop, msg)
`define SRSPLIT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/srsplit_pkg.sv
package srsplit_pkg;

    // Field widths
    localparam int OFF_W  = 40;
    localparam int SIZE_W = 32;
    localparam int TAG_W  = 31;
    localparam int TIME_W = 48;
    localparam int SRV_W  = 10;
    localparam int NS_W   = 11;
    localparam int ST_W   = 25;
    localparam int CST_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SERVERS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SEND_TIME = 2'd2;

    // Shared divider geometry
    localparam int DIV_W = 41;
    localparam int REM_W = 25;
    localparam int CNT_W = 6;

    localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [NS_W-1:0]   NS_LIMIT = 11'd1024;

    typedef struct packed {
        logic [OFF_W-1:0]  byte_offset;
        logic [SIZE_W-1:0] request_size;
        logic [TAG_W-1:0]  request_tag;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [SRV_W-1:0]  server_index;
        logic [ST_W-1:0]   chunk_size;
        logic [TIME_W-1:0] send_delay;
        logic              is_last;
        logic              overflow;
    } out_item_t;

    // Divider control from the sequencer
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/stripe_request_splitter_unit.sv
// Each accepted item runs four divisions (40, 31, 41 and 33 steps) one bit per cycle
// on a single shared divider before its first result.
// Results then leave one per cycle while out_stall is low, up to MAX_CHUNKS per item.
// A new item is taken only back in idle, after the S_FIN state commits sender time;
// an overflow item skips S_FIN, as it commits nothing.
// Reset (rst_n low, asynchronous): sender free time 0, stripe length 1048576,
// num_servers 16, chunk_send_time 1, no result pending.
`include "stripe_request_splitter_unit_macros.svh"

module stripe_request_splitter_unit #(
    parameter int MAX_CHUNKS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  srsplit_pkg::in_item_t              in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output srsplit_pkg::out_item_t             out_data,
    input  logic                               cfg_wr_en,
    input  logic [srsplit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srsplit_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srsplit_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_DIV3 = 3'd3;
    localparam logic [2:0] S_DIV4 = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Divider step counts per operation
    localparam logic [CNT_W-1:0] STEPS_OFF = 6'd40;
    localparam logic [CNT_W-1:0] STEPS_TAG = 6'd31;
    localparam logic [CNT_W-1:0] STEPS_SUM = 6'd41;
    localparam logic [CNT_W-1:0] STEPS_END = 6'd33;

    logic [2:0]        state_reg, state_next;
    logic [ST_W-1:0]   stripe_reg, stripe_next;
    logic [NS_W-1:0]   ns_reg, ns_next;
    logic [CST_W-1:0]  cst_reg, cst_next;
    logic [TIME_W-1:0] free_reg, free_next;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [OFF_W-1:0]  q_reg, q_next;
    logic [ST_W-1:0]   r_reg, r_next;
    logic [SRV_W-1:0]  srv_reg, srv_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  total_reg, total_next;
    logic [ST_W-1:0]   first_reg, first_next;
    logic [ST_W-1:0]   last_reg, last_next;
    logic              ovf_reg, ovf_next;
    logic [TIME_W-1:0] dly_reg, dly_next;
    logic [TIME_W-1:0] lim_reg, lim_next;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [ST_W-1:0]   eff_st;
    logic [NS_W-1:0]   eff_ns;
    logic              in_fire;
    logic              out_free;

    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [DIV_W-1:0]  div_quo;
    logic [REM_W-1:0]  div_rem;

    logic [SIZE_W:0]   end_sum;
    logic [ST_W-1:0]   rest;
    logic [32:0]       q2;
    logic              is_large;
    logic              is_fin;
    logic [ST_W-1:0]   chunk;
    logic [TIME_W:0]   dsum;
    logic [TIME_W-1:0] dnew;
    logic [NS_W-1:0]   srv_inc;

    // Effective configuration
    assign eff_st = (stripe_reg == '0) ? ST_W'(1) : stripe_reg;
    always_comb
    begin
        if (ns_reg == '0)
            eff_ns = NS_W'(1);
        else if (ns_reg > NS_LIMIT)
            eff_ns = NS_LIMIT;
        else
            eff_ns = ns_reg;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration writes
    always_comb
    begin
        stripe_next = stripe_reg;
        ns_next     = ns_reg;
        cst_next    = cst_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_STRIPE_SIZE:     stripe_next = cfg_data;
                CFG_NUM_SERVERS:     ns_next     = cfg_data[NS_W-1:0];
                CFG_CHUNK_SEND_TIME: cst_next    = cfg_data[CST_W-1:0];
                default:             ;
            endcase
        end
    end

    // Divider operand selection per step of the sequence
    assign end_sum = {8'b0, r_reg} + {1'b0, size_reg};

    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                div_req.start    = in_fire;
                div_req.dividend = {in_data.byte_offset, 1'b0};
                div_req.divisor  = eff_st;
                div_req.steps    = STEPS_OFF;
            end
            S_DIV1:
            begin
                div_req.start    = div_stat.done;
                div_req.dividend = {tag_reg, 10'b0};
                div_req.divisor  = REM_W'(eff_ns);
                div_req.steps    = STEPS_TAG;
            end
            S_DIV2:
            begin
                div_req.start    = div_stat.done;
                div_req.dividend = {1'b0, q_reg} + DIV_W'(div_rem[SRV_W-1:0]);
                div_req.divisor  = REM_W'(eff_ns);
                div_req.steps    = STEPS_SUM;
            end
            S_DIV3:
            begin
                div_req.start    = div_stat.done;
                div_req.dividend = {end_sum, 8'b0};
                div_req.divisor  = eff_st;
                div_req.steps    = STEPS_END;
            end
            default: ;
        endcase
    end

    srsplit_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Chunk plan terms
    assign q2       = div_quo[32:0];
    assign rest     = eff_st - r_reg;
    assign is_large = (size_reg >= SIZE_W'(eff_st));

    // Per-chunk terms
    assign is_fin  = (idx_reg == total_reg - 1'b1);
    assign chunk   = is_fin ? last_reg : ((idx_reg == '0) ? first_reg : eff_st);
    assign dsum    = {1'b0, dly_reg} + (TIME_W + 1)'(cst_reg);
    assign dnew    = (dsum > {1'b0, lim_reg}) ? lim_reg : dsum[TIME_W-1:0];
    assign srv_inc = {1'b0, srv_reg} + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        size_next      = size_reg;
        tag_next       = tag_reg;
        now_next       = now_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        srv_next       = srv_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        dly_next       = dly_reg;
        lim_next       = lim_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    size_next  = in_data.request_size;
                    tag_next   = in_data.request_tag;
                    now_next   = in_data.now_time;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                // offset / stripe
                if (div_stat.done)
                begin
                    q_next     = div_quo[OFF_W-1:0];
                    r_next     = div_rem;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                // tag mod servers
                if (div_stat.done)
                    state_next = S_DIV3;
            end
            S_DIV3:
            begin
                // start server
                if (div_stat.done)
                begin
                    srv_next   = div_rem[SRV_W-1:0];
                    state_next = S_DIV4;
                end
            end
            S_DIV4:
            begin
                // end of request within its stripes: plan the chunks
                if (div_stat.done)
                begin
                    idx_next = '0;
                    ovf_next = 1'b0;
                    if (is_large)
                    begin
                        ovf_next   = (q2 >= 33'(MAX_CHUNKS));
                        total_next = ovf_next ? IDX_W'(1) : IDX_W'(q2 + 33'd1);
                        first_next = rest;
                        last_next  = div_rem;
                    end
                    else if (size_reg <= SIZE_W'(rest))
                    begin
                        total_next = IDX_W'(1);
                        first_next = size_reg[ST_W-1:0];
                        last_next  = size_reg[ST_W-1:0];
                    end
                    else
                    begin
                        total_next = IDX_W'(2);
                        first_next = rest;
                        last_next  = size_reg[ST_W-1:0] - rest;
                    end
                    dly_next   = (free_reg > now_reg) ? (free_reg - now_reg) : '0;
                    lim_next   = TIME_MAX - now_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (ovf_reg)
                    begin
                        out_next          = '0;
                        out_next.is_last  = 1'b1;
                        out_next.overflow = 1'b1;
                    end
                    else
                    begin
                        out_next.server_index = srv_reg;
                        out_next.chunk_size   = chunk;
                        out_next.send_delay   = dnew;
                        out_next.is_last      = is_fin;
                        out_next.overflow     = 1'b0;
                        dly_next              = dnew;
                    end
                    srv_next = (srv_inc == eff_ns) ? '0 : srv_inc[SRV_W-1:0];
                    idx_next = idx_reg + 1'b1;
                    if (is_fin)
                        state_next = ovf_reg ? S_IDLE : S_FIN;
                end
            end
            S_FIN:
            begin
                // commit the sender reservation of the whole item
                free_next  = now_reg + dly_reg;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stripe_reg    <= 25'd1048576;
            ns_reg        <= 11'd16;
            cst_reg       <= 16'd1;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            total_reg     <= IDX_W'(1);
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stripe_reg    <= stripe_next;
            ns_reg        <= ns_next;
            cst_reg       <= cst_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        tag_reg   <= tag_next;
        now_reg   <= now_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        srv_reg   <= srv_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        dly_reg   <= dly_next;
        lim_reg   <= lim_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `SRSPLIT_ASSERT(a_ovf_is_last, (out_valid && out_data.overflow) |-> out_data.is_last, "overflow item not marked last")
    `SRSPLIT_ASSERT(a_free_only_fin, (state_reg != S_FIN) |=> $stable(free_reg), "sender time moved outside commit")
    `SRSPLIT_ASSERT(a_idx_bound, (state_reg == S_EMIT) |-> (idx_reg < total_reg), "chunk index past chunk count")
    `SRSPLIT_ASSERT(a_div_idle, (state_reg == S_IDLE || state_reg == S_EMIT) |-> !div_stat.busy, "divider busy outside division")

endmodule

// File: rtl/srsplit_div.sv
module srsplit_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srsplit_pkg::div_req_t         req,
    output srsplit_pkg::div_stat_t        stat,
    output logic [srsplit_pkg::DIV_W-1:0] quotient,
    output logic [srsplit_pkg::REM_W-1:0] remainder
);
    import srsplit_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dvs_reg, dvs_next;
    logic [REM_W:0]   shifted;
    logic [REM_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            // dividend arrives left-aligned, so the quotient lands in the low bits
            cnt_next = req.steps;
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
